@@ hdl/abfa_pkg.sv @@
// shared types, codes and helpers of the aligned bitmap first-fit allocator
package abfa_pkg;

    localparam int WORD_BITS = 64;
    localparam int ADDR_W    = 48;
    localparam int CNT_W     = 17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_BAD_ALIGN = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_SCAN  = 2'd0;
    localparam t_mode MODE_MARK  = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    // index of the lowest set bit, zero when none is set
    function automatic logic [5:0] lowest_set(input t_word w);
        logic [5:0] idx;
        idx = 6'd0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w[k]) begin
                idx = 6'(k);
            end
        end
        return idx;
    endfunction

endpackage

@@ hdl/aligned_bitmap_first_fit_allocator.sv @@
// top level: request sequencer that scans, marks and clears the used-bit map
//
//  channel  dir  handshake             payload
//  s        in   i_s_tvalid/o_s_tready  tuser opcode, tdata count/align/address
//  m        out  o_m_tvalid/i_m_tready  tdata granted_address, status
//  cfg      in   i_cfg_we               i_cfg_wdata pool_base
//
// one item at a time; an allocate is accepted and checked, then per candidate each
// map word it covers is read and checked, with a step to skip past a used byte,
// then each word is read again and marked and the result is loaded, so the work
// grows with occupancy; a free is accepted and checked, then each map word touched
// is read and cleared; after reset a clearing pass writes every map word with
// o_s_tready low; a finished result waits in the output register
module aligned_bitmap_first_fit_allocator import abfa_pkg::*; #(
    parameter int POOL_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,  // byte_count, alignment, free_address, zero fill
    input  logic        i_s_tuser,  // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata   // granted_address, status, zero fill
);

    localparam int MAP_WORDS = (POOL_BYTES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW = $clog2(POOL_BYTES + 131072) + 1;
    localparam logic [IW-1:0] POOL_I = IW'(POOL_BYTES);
    localparam logic [48:0] POOL_F = 49'(POOL_BYTES);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ACHK = 4'd2;
    localparam logic [3:0] S_FCHK = 4'd3;
    localparam logic [3:0] S_CAND = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_SKIP = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]        r_state;
    logic [AW-1:0]     r_clr_addr;
    logic [47:0]       r_pool_base;
    logic              r_op;
    logic [CNT_W-1:0]  r_size;
    logic [CNT_W-1:0]  r_align;
    logic [47:0]       r_where;
    logic [IW-1:0]     r_first;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_p;
    logic [IW-1:0]     r_e;
    logic [IW-1:0]     r_hit;
    t_mode             r_mode;
    logic [47:0]       r_res_addr;
    logic [1:0]        r_res_st;
    logic              r_ovalid;
    logic [47:0]       r_out_addr;
    logic [1:0]        r_out_st;

    t_word             rd_data;
    logic              ram_rd_en;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    t_word             ram_wr_data;

    logic [IW-1:0]     wbase;
    logic [IW-1:0]     span;
    t_word             mask;
    t_word             hits;
    logic [IW-1:0]     next_p;
    logic [IW-1:0]     cand_end;
    logic [CNT_W-1:0]  align_m1;
    logic [47:0]       free_off;
    logic [48:0]       free_end;

    abfa_map_ram #(.DEPTH(MAP_WORDS), .AW(AW)) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_p[AW+5:6]),
        .o_rd_data (rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    always_comb begin
        wbase    = {r_p[IW-1:6], 6'b0};
        span     = r_e - wbase;
        mask     = ({WORD_BITS{1'b1}} << r_p[5:0]) &
                   ((span >= IW'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                                             : ((t_word'(1) << span[5:0]) - t_word'(1)));
        hits     = rd_data & mask;
        next_p   = wbase + IW'(WORD_BITS);
        cand_end = r_i + IW'(r_size);
        align_m1 = r_align - CNT_W'(1);
        free_off = r_where - r_pool_base;
        free_end = {1'b0, free_off} + 49'(r_size);
    end

    always_comb begin
        ram_rd_en   = (r_state == S_RD);
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_p[AW+5:6];
        ram_wr_data = rd_data | mask;
        case (r_state)
            S_CLR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            S_CHK: begin
                ram_wr_en   = (r_mode != MODE_SCAN);
                ram_wr_data = (r_mode == MODE_MARK) ? (rd_data | mask) : (rd_data & ~mask);
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_pool_base <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_base <= i_cfg_wdata;
            end
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= i_s_tuser;
                        r_size  <= i_s_tdata[16:0];
                        r_align <= i_s_tdata[33:17];
                        r_where <= i_s_tdata[81:34];
                        r_state <= (i_s_tuser == OP_FREE) ? S_FCHK : S_ACHK;
                    end
                end
                S_ACHK: begin
                    r_res_addr <= '0;
                    if (r_align == '0 || (r_align & align_m1) != '0) begin
                        r_res_st <= ST_BAD_ALIGN;
                        r_state  <= S_OUT;
                    end else begin
                        r_first <= IW'((CNT_W'(0) - r_pool_base[CNT_W-1:0]) & align_m1);
                        r_i     <= IW'((CNT_W'(0) - r_pool_base[CNT_W-1:0]) & align_m1);
                        r_state <= S_CAND;
                    end
                end
                S_FCHK: begin
                    r_res_addr <= '0;
                    r_mode     <= MODE_CLEAR;
                    if (r_where < r_pool_base || free_end > POOL_F) begin
                        r_res_st <= ST_BAD_FREE;
                        r_state  <= S_OUT;
                    end else begin
                        r_res_st <= ST_OK;
                        r_p      <= IW'(free_off[19:0]);
                        r_e      <= IW'(free_end[20:0]);
                        r_state  <= (r_size == '0) ? S_OUT : S_RD;
                    end
                end
                S_CAND: begin
                    if (r_i >= POOL_I || cand_end > POOL_I) begin
                        r_res_st   <= ST_EXHAUSTED;
                        r_res_addr <= '0;
                        r_state    <= S_OUT;
                    end else if (r_size == '0) begin
                        r_res_st   <= ST_OK;
                        r_res_addr <= r_pool_base + 48'(r_i);
                        r_state    <= S_OUT;
                    end else begin
                        r_p     <= r_i;
                        r_e     <= cand_end;
                        r_mode  <= MODE_SCAN;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_mode == MODE_SCAN && hits != '0) begin
                        r_hit   <= wbase | IW'(lowest_set(hits));
                        r_state <= S_SKIP;
                    end else if (next_p >= r_e) begin
                        if (r_mode == MODE_SCAN) begin
                            // run is free: go back over it and mark it
                            r_p     <= r_i;
                            r_mode  <= MODE_MARK;
                            r_state <= S_RD;
                        end else begin
                            r_res_st   <= ST_OK;
                            r_res_addr <= (r_op == OP_ALLOC) ? (r_pool_base + 48'(r_i)) : '0;
                            r_state    <= S_OUT;
                        end
                    end else begin
                        r_p     <= next_p;
                        r_state <= S_RD;
                    end
                end
                S_SKIP: begin
                    // first aligned candidate beyond the used byte
                    r_i     <= r_first + (((r_hit - r_first) | IW'(align_m1)) + IW'(1));
                    r_state <= S_CAND;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid   <= 1'b1;
                        r_out_addr <= r_res_addr;
                        r_out_st   <= r_res_st;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_out_st, r_out_addr};

endmodule

@@ hdl/abfa_map_ram.sv @@
// used-bit map memory, one write port and one registered read port
module abfa_map_ram import abfa_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_word         o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_word         i_wr_data
);

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/abfa_checker.sv @@
// port-level checks of the allocator, bound to the top level
module abfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[49:48] != 2'd0 |-> o_m_tdata[47:0] == 48'd0)
        else $error("error result with nonzero address");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while busy");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("activity right after reset");

endmodule

bind aligned_bitmap_first_fit_allocator abfa_checker u_abfa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
